// ===== hw/rtl/jti_pkg.sv =====
// Shared constants for the joint trajectory interpolator.
package jti_pkg;

  // Fixed field widths.
  localparam int JOINT_W     = 6;
  localparam int ANGLE_W     = 24;
  localparam int RATIO_W     = 7;
  localparam int THR_W       = 23;
  localparam int FUNC_W      = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 23;

  // Default joint count.
  localparam int JTI_JOINTS = 40;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PRIME = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_RATIO     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SKIP      = 2'd2;

  // Register reset values; the threshold is 0.03 rad in Q7.16.
  localparam logic [RATIO_W-1:0] RATIO_RST = 7'd8;
  localparam logic [THR_W-1:0]   THR_RST   = 23'd1966;
  localparam logic [JOINT_W-1:0] SKIP_RST  = 6'd29;
  localparam logic [RATIO_W-1:0] RATIO_MAX = 7'd64;
  localparam logic [RATIO_W-1:0] RATIO_MIN = 7'd1;

  // Divider: product width and quotient bits retired per cycle.
  localparam int DIV_W     = 32;
  localparam int DIV_STEPS = 4;

endpackage

// ===== hw/rtl/jti_bank_mem.sv =====
// Angle bank memory: one write port, two registered read ports.
module jti_bank_mem #(
  parameter int DEPTH = 2 * jti_pkg::JTI_JOINTS,
  parameter int AW    = $clog2(2 * jti_pkg::JTI_JOINTS)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [jti_pkg::ANGLE_W-1:0] wdata,
  input  logic [AW-1:0]              raddr_a,
  input  logic [AW-1:0]              raddr_b,
  output logic [jti_pkg::ANGLE_W-1:0] rdata_a,
  output logic [jti_pkg::ANGLE_W-1:0] rdata_b
);
  import jti_pkg::*;

  logic [ANGLE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Both read ports are registered; the data follows the address in the next cycle.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/jti_div.sv =====
// Iterative unsigned divider, a few quotient bits per cycle.
module jti_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [jti_pkg::DIV_W-1:0]       dividend,
  input  logic [jti_pkg::RATIO_W-1:0]     divisor,
  output logic                            done,
  output logic [jti_pkg::DIV_W-1:0]       quotient
);
  import jti_pkg::*;

  localparam int ITER = DIV_W / DIV_STEPS;
  localparam int CW   = (ITER > 1) ? $clog2(ITER) : 1;

  logic              active;
  logic [CW-1:0]     cnt;
  logic [RATIO_W-1:0] rem;
  logic [DIV_W-1:0]  dq;
  logic [RATIO_W-1:0] rem_next;
  logic [DIV_W-1:0]  dq_next;

  // Restoring division steps for one cycle; dq shifts dividend out and quotient in.
  always_comb begin
    logic [RATIO_W:0] shifted;
    rem_next = rem;
    dq_next  = dq;
    for (int s = 0; s < DIV_STEPS; s++) begin
      shifted = {rem_next, dq_next[DIV_W-1]};
      dq_next = {dq_next[DIV_W-2:0], 1'b0};
      if (shifted >= {1'b0, divisor}) begin
        shifted    = shifted - {1'b0, divisor};
        dq_next[0] = 1'b1;
      end
      rem_next = shifted[RATIO_W-1:0];
    end
  end

  // Iteration control and done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        dq     <= dividend;
      end else if (active) begin
        rem <= rem_next;
        dq  <= dq_next;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(ITER - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign quotient = dq;

endmodule

// ===== hw/rtl/joint_trajectory_interpolator.sv =====
// Top level: command port, configuration registers and the tick sequencer.
// Load, prime and unused function words finish at the accepting edge; busy stays low.
// A tick walks the joints one at a time: each emitted joint takes a bank read, a multiply,
// the divider launch, the divide iterations at 4 quotient bits each and the result output,
// while a skipped slot is only passed over in the read state, with no multiply or divide.
// Results are one-cycle strobes that the receiver cannot stall.
// Synchronous reset clears the sequencer, bank select, phase and registers; bank contents stay.
module joint_trajectory_interpolator #(
  parameter int JOINTS = jti_pkg::JTI_JOINTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [jti_pkg::FUNC_W-1:0]        func,
  input  logic [jti_pkg::JOINT_W-1:0]       joint,
  input  logic signed [jti_pkg::ANGLE_W-1:0] angle,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [jti_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [jti_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              strobe,
  output logic [jti_pkg::JOINT_W-1:0]       out_joint,
  output logic signed [jti_pkg::ANGLE_W-1:0] out_angle,
  output logic                              jump,
  output logic                              last
);
  import jti_pkg::*;

  localparam int AW = (2 * JOINTS > 2) ? $clog2(2 * JOINTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_DIVGO,
    S_DIVW
  } state_t;

  state_t state;

  // Configuration and frame state.
  logic [RATIO_W-1:0] ratio;
  logic [THR_W-1:0]   threshold;
  logic [JOINT_W-1:0] skip;
  logic               bank_sel;
  logic [JOINT_W-1:0] phase;

  // Per-tick working registers.
  logic [JOINT_W-1:0] j;
  logic [RATIO_W-1:0] r_cur;
  logic [RATIO_W-1:0] k_cur;
  logic [ANGLE_W-1:0] p_reg;
  logic               neg;
  logic               jump_cur;
  logic [DIV_W-1:0]   prod;

  logic                accept;
  logic [RATIO_W-1:0]  r_clamp;
  logic [RATIO_W-1:0]  k_raw;
  logic [RATIO_W-1:0]  k_sel;
  logic [RATIO_W:0]    last_idx;
  logic                at_end;
  logic                is_last;
  logic                frame_end;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       tgt_addr;
  logic [AW-1:0]       prv_addr;
  logic [ANGLE_W-1:0]  t_data;
  logic [ANGLE_W-1:0]  p_data;
  logic [ANGLE_W:0]    diff;
  logic [ANGLE_W:0]    diff_abs;
  logic                div_start;
  logic                div_done;
  logic [DIV_W-1:0]    div_quo;
  logic [ANGLE_W+1:0]  q_ext;
  logic [ANGLE_W+1:0]  q_sgn;
  logic [ANGLE_W+1:0]  v_sum;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  // Register writes wait until no tick is running or being started.
  assign cfg_ready = !busy && !start;

  // Ratio clamp and tick number within the frame.
  always_comb begin
    if (ratio == '0) begin
      r_clamp = RATIO_MIN;
    end else if (ratio > RATIO_MAX) begin
      r_clamp = RATIO_MAX;
    end else begin
      r_clamp = ratio;
    end
    k_raw = {1'b0, phase} + RATIO_W'(1);
    k_sel = (k_raw > r_clamp) ? r_clamp : k_raw;
  end

  // Last emitted slot is the top one unless that one is skipped.
  assign last_idx  = ({2'b0, skip} == (RATIO_W + 1)'(JOINTS - 1)) ?
                     (RATIO_W + 1)'(JOINTS - 2) : (RATIO_W + 1)'(JOINTS - 1);
  assign at_end    = ({2'b0, j} == (RATIO_W + 1)'(JOINTS - 1));
  assign is_last   = ({2'b0, j} == last_idx);
  assign frame_end = (k_cur >= r_cur);

  // Bank addressing: the target bank is bank_sel, the previous bank the other.
  assign we       = accept && (func == FUNC_LOAD) && ({1'b0, joint} < 7'(JOINTS));
  assign waddr    = bank_sel ? AW'(JOINTS) + AW'(joint) : AW'(joint);
  assign tgt_addr = bank_sel ? AW'(JOINTS) + AW'(j) : AW'(j);
  assign prv_addr = bank_sel ? AW'(j) : AW'(JOINTS) + AW'(j);

  jti_bank_mem #(
    .DEPTH (2 * JOINTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (angle),
    .raddr_a (tgt_addr),
    .raddr_b (prv_addr),
    .rdata_a (t_data),
    .rdata_b (p_data)
  );

  // Difference and its magnitude from the bank read data.
  assign diff     = {t_data[ANGLE_W-1], t_data} - {p_data[ANGLE_W-1], p_data};
  assign diff_abs = diff[ANGLE_W] ? (ANGLE_W + 1)'(-diff) : diff;

  assign div_start = (state == S_DIVGO);

  jti_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (r_cur),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Signed step added to the previous angle; the quotient never exceeds |diff|.
  assign q_ext = {1'b0, div_quo[ANGLE_W:0]};
  assign q_sgn = neg ? (ANGLE_W + 2)'(-q_ext) : q_ext;
  assign v_sum = {{2{p_reg[ANGLE_W-1]}}, p_reg} + q_sgn;

  // Sequencer, configuration registers and registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ratio     <= RATIO_RST;
      threshold <= THR_RST;
      skip      <= SKIP_RST;
      bank_sel  <= 1'b0;
      phase     <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;

      // Configuration words.
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_RATIO:     ratio     <= cfg_data[RATIO_W-1:0];
          CFG_THRESHOLD: threshold <= cfg_data[THR_W-1:0];
          CFG_SKIP:      skip      <= cfg_data[JOINT_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (func == FUNC_PRIME) begin
              bank_sel <= !bank_sel;
              phase    <= '0;
            end else if (func == FUNC_TICK) begin
              r_cur <= r_clamp;
              k_cur <= k_sel;
              j     <= '0;
              state <= S_READ;
            end
          end
        end

        // Skipped slots are passed over in this state; otherwise the addresses go out now.
        S_READ: begin
          if (j == skip) begin
            if (at_end) begin
              if (frame_end) begin
                bank_sel <= !bank_sel;
                phase    <= '0;
              end else begin
                phase <= k_cur[JOINT_W-1:0];
              end
              state <= S_IDLE;
            end else begin
              j <= j + JOINT_W'(1);
            end
          end else begin
            state <= S_CALC;
          end
        end

        // Scale the magnitude of the difference by the tick number.
        S_CALC: begin
          p_reg    <= p_data;
          neg      <= diff[ANGLE_W];
          jump_cur <= (diff_abs > {2'b0, threshold});
          prod     <= {{(DIV_W - ANGLE_W - 1){1'b0}}, diff_abs} *
                      {{(DIV_W - RATIO_W){1'b0}}, k_cur};
          state    <= S_DIVGO;
        end

        S_DIVGO: begin
          state <= S_DIVW;
        end

        // Emit one word when the quotient is ready.
        S_DIVW: begin
          if (div_done) begin
            strobe    <= 1'b1;
            out_joint <= j;
            out_angle <= v_sum[ANGLE_W-1:0];
            jump      <= jump_cur;
            last      <= is_last;
            if (at_end) begin
              if (frame_end) begin
                bank_sel <= !bank_sel;
                phase    <= '0;
              end else begin
                phase <= k_cur[JOINT_W-1:0];
              end
              state <= S_IDLE;
            end else begin
              j     <= j + JOINT_W'(1);
              state <= S_READ;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Result words are spaced by the divider, never in adjacent cycles.
  a_strobe_spaced: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("result words in adjacent cycles");

  // The skipped slot never shows up on the result port.
  a_no_skipped: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (out_joint != skip))
    else $error("skipped joint emitted");

  // An accepted tick always starts the sequencer.
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_TICK) |=> busy)
    else $error("tick accepted without starting");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW))
    else $error("divider finished outside its wait state");

endmodule
